// ----- rtl/complex_arith_unit_assert.svh -----
// assertion macros shared by the checker
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH

// checked only outside reset
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// types, codes and helpers of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIV_STEPS = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sat_t;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  st;
  } res_t;

  // front end result: exact sums, product terms and the divisor
  typedef struct packed {
    op_t                op;
    logic               dz;
    logic signed [32:0] sum_re;
    logic signed [32:0] sum_im;
    logic signed [64:0] w_re;
    logic signed [64:0] w_im;
    logic [63:0]        d;
  } fr_t;

  // one divider lane: partial remainder, pending numerator bits, quotient
  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [63:0] rem;
    logic [31:0] nlo;
    logic [31:0] q;
  } lane_t;

  typedef struct packed {
    logic        is_div;
    logic        dz;
    res_t        pre;
    logic [63:0] d;
    lane_t       re;
    lane_t       im;
  } dstg_t;

  function automatic sat_t clamp65(input logic signed [64:0] v);
    sat_t s;
    s.sat = 1'b0;
    s.val = v[31:0];
    if (v > 65'sd2147483647) begin
      s.sat = 1'b1;
      s.val = 32'h7fff_ffff;
    end else if (v < -65'sd2147483648) begin
      s.sat = 1'b1;
      s.val = 32'h8000_0000;
    end
    return s;
  endfunction

endpackage

// ----- rtl/cau_front.sv -----
// ----------------------------------------------------------------------------
// cau_front
// operand products, exact sums and the divisor, two register stages
// ----------------------------------------------------------------------------
module cau_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  cau_pkg::op_t       op,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               fr_v,
  output cau_pkg::fr_t       fr
);

  logic               s1_v_r;
  cau_pkg::op_t       s1_op_r;
  logic               s1_dz_r;
  logic signed [32:0] s1_sum_re_r, s1_sum_im_r;
  logic signed [63:0] s1_rr_r, s1_ii_r, s1_ir_r, s1_ri_r, s1_sr_r, s1_si_r;
  logic signed [32:0] sum_re_nxt, sum_im_nxt;
  logic               s2_v_r;
  cau_pkg::fr_t       s2_r, s2_nxt;

  always_comb begin
    if (op == cau_pkg::OP_SUB) begin
      sum_re_nxt = {a_re[31], a_re} - {b_re[31], b_re};
      sum_im_nxt = {a_im[31], a_im} - {b_im[31], b_im};
    end else begin
      sum_re_nxt = {a_re[31], a_re} + {b_re[31], b_re};
      sum_im_nxt = {a_im[31], a_im} + {b_im[31], b_im};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r     <= op;
      s1_dz_r     <= (b_re == 32'sd0) && (b_im == 32'sd0);
      s1_sum_re_r <= sum_re_nxt;
      s1_sum_im_r <= sum_im_nxt;
      s1_rr_r     <= a_re * b_re;
      s1_ii_r     <= a_im * b_im;
      s1_ir_r     <= a_im * b_re;
      s1_ri_r     <= a_re * b_im;
      s1_sr_r     <= b_re * b_re;
      s1_si_r     <= b_im * b_im;
    end
  end

  always_comb begin
    s2_nxt.op     = s1_op_r;
    s2_nxt.dz     = s1_dz_r;
    s2_nxt.sum_re = s1_sum_re_r;
    s2_nxt.sum_im = s1_sum_im_r;
    s2_nxt.d      = 64'(s1_sr_r) + 64'(s1_si_r);
    if (s1_op_r == cau_pkg::OP_DIV) begin
      s2_nxt.w_re = 65'(s1_rr_r) + 65'(s1_ii_r);
      s2_nxt.w_im = 65'(s1_ir_r) - 65'(s1_ri_r);
    end else begin
      s2_nxt.w_re = 65'(s1_rr_r) - 65'(s1_ii_r);
      s2_nxt.w_im = 65'(s1_ir_r) + 65'(s1_ri_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

  assign fr_v = s2_v_r;
  assign fr   = s2_r;

endmodule

// ----- rtl/cau_prep.sv -----
// ----------------------------------------------------------------------------
// cau_prep
// finishes add, subtract and multiply; sets up the divider lanes
// ----------------------------------------------------------------------------
module cau_prep (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           fr_v,
  input  cau_pkg::fr_t   fr,
  output logic           ds_v,
  output cau_pkg::dstg_t ds
);

  typedef struct packed {
    logic          is_div;
    logic          dz;
    cau_pkg::res_t pre;
    logic [63:0]   d;
    logic          neg_re;
    logic [63:0]   mag_re;
    logic          neg_im;
    logic [63:0]   mag_im;
  } mg_t;

  logic               s3_v_r;
  mg_t                s3_r, s3_nxt;
  logic               s4_v_r;
  cau_pkg::dstg_t     s4_r, s4_nxt;
  cau_pkg::sat_t      c_re, c_im;
  logic signed [64:0] sh_re, sh_im;
  logic [63:0]        top_re, top_im;

  always_comb begin
    sh_re = fr.w_re >>> cau_pkg::FRAC_BITS;
    sh_im = fr.w_im >>> cau_pkg::FRAC_BITS;
    if (fr.op == cau_pkg::OP_MUL) begin
      c_re = cau_pkg::clamp65(sh_re);
      c_im = cau_pkg::clamp65(sh_im);
    end else begin
      c_re = cau_pkg::clamp65(65'(fr.sum_re));
      c_im = cau_pkg::clamp65(65'(fr.sum_im));
    end
    s3_nxt.is_div = (fr.op == cau_pkg::OP_DIV);
    s3_nxt.dz     = fr.dz;
    s3_nxt.d      = fr.d;
    s3_nxt.pre.re = c_re.val;
    s3_nxt.pre.im = c_im.val;
    s3_nxt.pre.st = (c_re.sat || c_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    // magnitudes never exceed 2^63, so 64 bits hold them
    s3_nxt.neg_re = fr.w_re[64];
    s3_nxt.mag_re = fr.w_re[64] ? 64'(-fr.w_re) : fr.w_re[63:0];
    s3_nxt.neg_im = fr.w_im[64];
    s3_nxt.mag_im = fr.w_im[64] ? 64'(-fr.w_im) : fr.w_im[63:0];
  end

  always_comb begin
    // numerator is mag << FRAC_BITS; the part above bit 31 seeds the remainder
    top_re = s3_r.mag_re >> (32 - cau_pkg::FRAC_BITS);
    top_im = s3_r.mag_im >> (32 - cau_pkg::FRAC_BITS);
    s4_nxt.is_div = s3_r.is_div;
    s4_nxt.dz     = s3_r.dz;
    s4_nxt.pre    = s3_r.pre;
    s4_nxt.d      = s3_r.d;
    s4_nxt.re.neg = s3_r.neg_re;
    s4_nxt.re.ovf = (top_re >= s3_r.d);
    s4_nxt.re.rem = (top_re >= s3_r.d) ? 64'd0 : top_re;
    s4_nxt.re.nlo = s3_r.mag_re[31:0] << cau_pkg::FRAC_BITS;
    s4_nxt.re.q   = 32'd0;
    s4_nxt.im.neg = s3_r.neg_im;
    s4_nxt.im.ovf = (top_im >= s3_r.d);
    s4_nxt.im.rem = (top_im >= s3_r.d) ? 64'd0 : top_im;
    s4_nxt.im.nlo = s3_r.mag_im[31:0] << cau_pkg::FRAC_BITS;
    s4_nxt.im.q   = 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= fr_v;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
    end
  end

  assign ds_v = s4_v_r;
  assign ds   = s4_r;

endmodule

// ----- rtl/cau_div_step.sv -----
// ----------------------------------------------------------------------------
// cau_div_step
// one restoring divide step for both lanes, registered
// ----------------------------------------------------------------------------
module cau_div_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           i_v,
  input  cau_pkg::dstg_t i_s,
  output logic           o_v,
  output cau_pkg::dstg_t o_s
);

  logic           v_r;
  cau_pkg::dstg_t s_r, s_nxt;

  function automatic cau_pkg::lane_t step(input cau_pkg::lane_t l, input logic [63:0] d);
    cau_pkg::lane_t n;
    logic [64:0]    r2;
    logic [64:0]    df;
    n  = l;
    r2 = {l.rem, l.nlo[31]};
    df = r2 - {1'b0, d};
    n.nlo = {l.nlo[30:0], 1'b0};
    if (!df[64]) begin
      n.rem = df[63:0];
      n.q   = {l.q[30:0], 1'b1};
    end else begin
      n.rem = r2[63:0];
      n.q   = {l.q[30:0], 1'b0};
    end
    return n;
  endfunction

  always_comb begin
    s_nxt    = i_s;
    s_nxt.re = step(i_s.re, i_s.d);
    s_nxt.im = step(i_s.im, i_s.d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= i_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  assign o_v = v_r;
  assign o_s = s_r;

endmodule

// ----- rtl/cau_back.sv -----
// ----------------------------------------------------------------------------
// cau_back
// quotient sign and saturation, status, output register
// ----------------------------------------------------------------------------
module cau_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           i_v,
  input  cau_pkg::dstg_t i_s,
  output logic           out_v,
  output cau_pkg::res_t  out_res
);

  logic          v_r;
  cau_pkg::res_t res_r, res_nxt;
  cau_pkg::sat_t f_re, f_im;

  function automatic cau_pkg::sat_t fin(input cau_pkg::lane_t l);
    cau_pkg::sat_t s;
    logic [32:0]   lim;
    logic [32:0]   mag;
    lim   = l.neg ? 33'h0_8000_0000 : 33'h0_7fff_ffff;
    s.sat = l.ovf || ({1'b0, l.q} > lim);
    mag   = s.sat ? lim : {1'b0, l.q};
    s.val = l.neg ? 32'(-mag) : mag[31:0];
    return s;
  endfunction

  always_comb begin
    f_re = fin(i_s.re);
    f_im = fin(i_s.im);
    if (!i_s.is_div) begin
      res_nxt = i_s.pre;
    end else if (i_s.dz) begin
      res_nxt.re = 32'd0;
      res_nxt.im = 32'd0;
      res_nxt.st = cau_pkg::ST_DZ;
    end else begin
      res_nxt.re = f_re.val;
      res_nxt.im = f_im.val;
      res_nxt.st = (f_re.sat || f_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= i_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_v   = v_r;
  assign out_res = res_r;

endmodule

// ----- rtl/complex_arith_unit.sv -----
// every operation takes the same path through the pipeline, from input accept to output valid
// one item per cycle while the output is not stalled; the whole pipeline advances together
// depth is set by the 32-stage restoring divider, one quotient bit per stage
// a stalled output register holds the pipeline; no item is lost or repeated
// reset (rst_n low, synchronous) clears every stage valid bit
// ----------------------------------------------------------------------------
// complex_arith_unit
// pipelined complex add, subtract, multiply and divide in signed Q16.16
// ----------------------------------------------------------------------------
module complex_arith_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [127:0]  in_tdata,   // a_re, a_im, b_re, b_im
  input  logic [1:0]    in_tuser,   // op
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata,  // res_re, res_im
  output logic [1:0]    out_tuser   // status
);

  logic           en;
  logic           fr_v;
  cau_pkg::fr_t   fr;
  logic           st_v [cau_pkg::DIV_STEPS+1];
  cau_pkg::dstg_t st_s [cau_pkg::DIV_STEPS+1];
  cau_pkg::res_t  res;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  cau_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (in_tvalid),
    .op    (cau_pkg::op_t'(in_tuser)),
    .a_re  (in_tdata[31:0]),
    .a_im  (in_tdata[63:32]),
    .b_re  (in_tdata[95:64]),
    .b_im  (in_tdata[127:96]),
    .fr_v  (fr_v),
    .fr    (fr)
  );

  cau_prep u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .fr_v  (fr_v),
    .fr    (fr),
    .ds_v  (st_v[0]),
    .ds    (st_s[0])
  );

  for (genvar g = 0; g < cau_pkg::DIV_STEPS; g++) begin : g_div
    cau_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .i_v   (st_v[g]),
      .i_s   (st_s[g]),
      .o_v   (st_v[g+1]),
      .o_s   (st_s[g+1])
    );
  end

  cau_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .i_v     (st_v[cau_pkg::DIV_STEPS]),
    .i_s     (st_s[cau_pkg::DIV_STEPS]),
    .out_v   (out_tvalid),
    .out_res (res)
  );

  assign out_tdata = {res.im, res.re};
  assign out_tuser = res.st;

endmodule

// ----- rtl/cau_checker.sv -----
// ----------------------------------------------------------------------------
// cau_checker
// port-level checks of the complex arithmetic unit
// ----------------------------------------------------------------------------
`include "complex_arith_unit_assert.svh"

module cau_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_tready,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [63:0]   out_tdata,
  input logic [1:0]    out_tuser
);

  logic out_dz;

  assign out_dz = out_tvalid && (out_tuser == cau_pkg::ST_DZ);

  `CAU_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "output item dropped")
  `CAU_ASSERT(a_status_code, out_tvalid |-> out_tuser <= cau_pkg::ST_SAT, "undefined status")
  `CAU_ASSERT(a_dz_zero, out_dz |-> out_tdata == 64'd0, "divide by zero result not zero")
  `CAU_ASSERT(a_ready, in_tready == (!out_tvalid || out_tready), "ready not tied to stall")
  `CAU_ASSERT_ALWAYS(a_reset, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind complex_arith_unit cau_checker u_cau_checker (.*);

// ----- sim/cau_checker.sv -----
// ----------------------------------------------------------------------------
// cau_tb_checker
// watches both channels of the complex arithmetic unit, predicts each result
// from the accepted operands and compares it with what comes out, in order
// ----------------------------------------------------------------------------
module cau_tb_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,
  input  logic [1:0]   out_tuser,
  output int           n_errors,
  output int           n_pending
);

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  st;
  } cplx_res_t;

  cplx_res_t results_due[$];

  // clamp an exact value to 32 bits, noting saturation
  function automatic logic [31:0] clamp_part(input logic signed [127:0] v, inout bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1;
      return 32'h7fff_ffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // exact numerator times 2^FRAC_BITS over d, truncated toward zero
  function automatic logic signed [127:0] quot_trunc(input logic signed [127:0] n,
                                                     input logic signed [127:0] d);
    logic signed [127:0] mag;
    logic signed [127:0] q;
    mag = (n < 0) ? -n : n;
    q = (mag <<< cau_pkg::FRAC_BITS) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic cplx_res_t complex_result(input logic [1:0] op, input logic [127:0] data);
    logic signed [127:0] ar, ai, br, bi, d, xr, xi;
    cplx_res_t r;
    bit sat;
    ar = $signed(data[31:0]);
    ai = $signed(data[63:32]);
    br = $signed(data[95:64]);
    bi = $signed(data[127:96]);
    sat = 0;
    r = '0;
    r.st = cau_pkg::ST_OK;
    case (op)
      cau_pkg::OP_ADD: begin
        xr = ar + br;
        xi = ai + bi;
      end
      cau_pkg::OP_SUB: begin
        xr = ar - br;
        xi = ai - bi;
      end
      cau_pkg::OP_MUL: begin
        xr = (ar * br - ai * bi) >>> cau_pkg::FRAC_BITS;
        xi = (ai * br + ar * bi) >>> cau_pkg::FRAC_BITS;
      end
      default: begin
        d = br * br + bi * bi;
        if (d != 0) begin
          xr = quot_trunc(ar * br + ai * bi, d);
          xi = quot_trunc(ai * br - ar * bi, d);
        end
      end
    endcase
    if (op == cau_pkg::OP_DIV && d == 0) begin
      r.st = cau_pkg::ST_DZ;
    end else begin
      r.re = clamp_part(xr, sat);
      r.im = clamp_part(xi, sat);
      if (sat) r.st = cau_pkg::ST_SAT;
    end
    return r;
  endfunction

  assign n_pending = results_due.size();

  always @(posedge clk) begin
    cplx_res_t want;
    if (!rst_n) begin
      n_errors <= 0;
    end else begin
      if (in_tvalid && in_tready) results_due.push_back(complex_result(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          if (n_errors < 10) $display("unexpected result %h st %0d", out_tdata, out_tuser);
          n_errors <= n_errors + 1;
        end else begin
          want = results_due.pop_front();
          if (out_tdata[31:0] !== want.re || out_tdata[63:32] !== want.im ||
              out_tuser !== want.st) begin
            if (n_errors < 10)
              $display("mismatch: exp re %h im %h st %0d, got re %h im %h st %0d",
                       want.re, want.im, want.st, out_tdata[31:0], out_tdata[63:32],
                       out_tuser);
            n_errors <= n_errors + 1;
          end
        end
      end
    end
  end

endmodule

// ----- sim/tb_complex_arith_unit.sv -----
// ----------------------------------------------------------------------------
// tb_complex_arith_unit
// directed corner operands then random add, subtract, multiply and divide
// items with random gaps on both sides and one long output hold-off
// ----------------------------------------------------------------------------
module tb_complex_arith_unit;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic [1:0]   out_tuser;
  int           n_errors;
  int           n_pending;
  int           cycle_count;
  bit           hold_off;

  complex_arith_unit dut (.*);

  cau_tb_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // fail-safe limit on simulated cycles
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h1;
      4, 5: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
      6, 7: return $signed(32'($urandom)) >>> $urandom_range(4, 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input cau_pkg::op_t op, input logic [31:0] ar,
                           input logic [31:0] ai, input logic [31:0] br,
                           input logic [31:0] bi);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {bi, br, ai, ar};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: random stalls, with stall-free stretches and one long hold-off
  initial begin
    int wait_n;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
      end else if (cycle_count % 3000 < 1000) begin
        out_tready <= 1'b1;
      end else begin
        wait_n = $urandom_range(0, 13);
        if (wait_n > 0) begin
          out_tready <= 1'b0;
          repeat (wait_n) @(negedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
        while (!out_tvalid) @(posedge clk);
      end
    end
  end

  initial begin
    hold_off = 0;
    wait (cycle_count == 400);
    hold_off = 1;
    repeat (300) @(posedge clk);
    hold_off = 0;
  end

  initial begin
    cau_pkg::op_t ops[4];
    logic [31:0] ext[6];
    ops = '{cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL, cau_pkg::OP_DIV};
    ext = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h0001_0000, 32'hffff_0000};
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = cau_pkg::OP_ADD;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // extremes for every operation, including divide by zero
    foreach (ops[k]) begin
      send_item(ops[k], ext[0], ext[0], ext[0], ext[0]);
      send_item(ops[k], ext[1], ext[1], ext[1], ext[1]);
      send_item(ops[k], ext[1], ext[0], ext[0], ext[1]);
      send_item(ops[k], ext[4], ext[5], ext[2], ext[2]);
      send_item(ops[k], ext[3], ext[3], ext[3], ext[4]);
    end
    send_item(cau_pkg::OP_DIV, ext[0], ext[1], ext[3], ext[2]);
    send_item(cau_pkg::OP_DIV, ext[4], ext[4], ext[4], ext[4]);
    for (int n = 0; n < 1300; n++) begin
      if (n % 10 == 0)
        send_item(cau_pkg::op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                  $urandom);
      else
        send_item(cau_pkg::op_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                  pick_operand(), pick_operand());
    end
    in_tvalid <= 1'b0;
    while (n_pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
